### src/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and helpers for the quaternion to euler angle block.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

  localparam int QuatW    = 16;
  localparam int AngW     = 16;
  localparam int FracBits = 14;
  localparam int ProdW    = 2 * QuatW;
  localparam int SumW     = ProdW + 4;
  localparam int S30W     = 32;
  localparam int CordW    = 40;
  localparam int AccW     = 32;
  localparam int RootW    = 31;
  localparam int RadW     = 2 * RootW;
  localparam int RemW     = RootW + 3;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic [AccW-1:0]         ang;
    logic                    zero;
  } cordic_vec_t;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [SumW-1:0] sr;
    logic signed [SumW-1:0] cr;
    logic signed [SumW-1:0] sy;
    logic signed [SumW-1:0] cy;
    logic signed [S30W-1:0] s30;
    logic                   hi;
    logic                   lo;
  } side_t;

  typedef struct packed {
    logic hi;
    logic lo;
  } clamp_t;

  function automatic logic [AccW-1:0] atan_at(input int i);
    logic [AccW-1:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // zero detect and fold into the right half plane
  function automatic cordic_vec_t prep(input logic signed [CordW-1:0] y,
                                       input logic signed [CordW-1:0] x);
    cordic_vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x[CordW-1]) begin
      v.x   = -x;
      v.y   = -y;
      v.ang = 32'h80000000;
    end else begin
      v.x   = x;
      v.y   = y;
      v.ang = '0;
    end
    return v;
  endfunction

  function automatic logic [AngW-1:0] round_ang(input cordic_vec_t v);
    logic [AngW-1:0] r;
    r = v.ang[AccW-1 -: AngW] + {{(AngW-1){1'b0}}, v.ang[AccW-AngW-1]};
    return v.zero ? '0 : r;
  endfunction

endpackage

`default_nettype wire

### src/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One digit step of a pipelined floor square root, two radicand bits a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_sqrt_cell (
  input  wire             clk_i,
  input  wire             en_i,
  input  qte_pkg::sqrt_t  in_i,
  output qte_pkg::sqrt_t  out_o
);

  logic [qte_pkg::RemW-1:0] rem_sh;
  logic [qte_pkg::RemW-1:0] trial;
  qte_pkg::sqrt_t           out_d, out_q;

  always_comb begin
    rem_sh = {in_i.rem[qte_pkg::RemW-3:0], in_i.rad[qte_pkg::RadW-1 -: 2]};
    trial  = {1'b0, in_i.root, 2'b01};
    out_d.rad = {in_i.rad[qte_pkg::RadW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      out_d.rem  = rem_sh - trial;
      out_d.root = {in_i.root[qte_pkg::RootW-2:0], 1'b1};
    end else begin
      out_d.rem  = rem_sh;
      out_d.root = {in_i.root[qte_pkg::RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

### src/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring micro-rotation of the CORDIC chain.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic_cell #(
  parameter int Idx = 0
) (
  input  wire                   clk_i,
  input  wire                   en_i,
  input  qte_pkg::cordic_vec_t  in_i,
  output qte_pkg::cordic_vec_t  out_o
);

  localparam int Sh = Idx % 64;
  localparam logic [qte_pkg::AccW-1:0] Step = qte_pkg::atan_at(Idx % 32);

  qte_pkg::cordic_vec_t out_d, out_q;

  always_comb begin
    out_d.zero = in_i.zero;
    if (!in_i.y[qte_pkg::CordW-1]) begin
      out_d.x   = in_i.x + (in_i.y >>> Sh);
      out_d.y   = in_i.y - (in_i.x >>> Sh);
      out_d.ang = in_i.ang + Step;
    end else begin
      out_d.x   = in_i.x - (in_i.y >>> Sh);
      out_d.y   = in_i.y + (in_i.x >>> Sh);
      out_d.ang = in_i.ang - Step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

### src/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Quaternion to zyx euler angles through a square root chain and three
// cordic vectoring chains.
// ----------------------------------------------------------------------------
//  port group   dir  tdata                        tuser
//  s_axis       in   w, x, y, z (16 b each)       -
//  m_axis       out  roll, pitch, yaw (16 b each) pitch_clamped
//
//  one beat a cycle, through the front end registers,
//  the 31 square root cells and the cordic cells
//  the whole pipe stalls while the output beat waits
//  reset clears the valid bits only
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic        m_axis_tuser    // pitch_clamped
);

  localparam int NSq = qte_pkg::RootW;
  localparam int SumW = qte_pkg::SumW;
  localparam int CordW = qte_pkg::CordW;
  localparam logic signed [SumW-1:0] One = SumW'(64'sd1 <<< (2 * qte_pkg::FracBits));

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // front end
  logic                          v1_q, v2_q, v3_q, v4_q;
  logic signed [15:0]            w_q, x_q, y_q, z_q;
  logic signed [31:0]            wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  qte_pkg::side_t                side3_d, side3_q, side4_q;
  logic [qte_pkg::RadW-1:0]      sq_q;
  logic signed [SumW-1:0]        sp;
  logic [qte_pkg::RootW-1:0]     mag;

  always_comb begin
    sp = 2 * (SumW'(wy_q) - SumW'(zx_q));
    side3_d.sr  = 2 * (SumW'(wx_q) + SumW'(yz_q));
    side3_d.cr  = One - 2 * (SumW'(xx_q) + SumW'(yy_q));
    side3_d.sy  = 2 * (SumW'(wz_q) + SumW'(xy_q));
    side3_d.cy  = One - 2 * (SumW'(yy_q) + SumW'(zz_q));
    side3_d.s30 = qte_pkg::S30W'(sp <<< 2);
    side3_d.hi  = sp >= One;
    side3_d.lo  = sp <= -One;
    mag = side3_q.s30[qte_pkg::S30W-1] ? qte_pkg::RootW'(-side3_q.s30)
                                       : qte_pkg::RootW'(side3_q.s30);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q <= s_axis_tdata[15:0];
      x_q <= s_axis_tdata[31:16];
      y_q <= s_axis_tdata[47:32];
      z_q <= s_axis_tdata[63:48];
      wx_q <= w_q * x_q;
      yz_q <= y_q * z_q;
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      wz_q <= w_q * z_q;
      xy_q <= x_q * y_q;
      zz_q <= z_q * z_q;
      wy_q <= w_q * y_q;
      zx_q <= z_q * x_q;
      side3_q <= side3_d;
      side4_q <= side3_q;
      sq_q <= mag * mag;
    end
  end

  // square root chain with side payload alongside
  qte_pkg::sqrt_t sq_st [NSq+1];
  qte_pkg::side_t side_st [NSq+1];
  logic [NSq:0]   sv_q;

  always_comb begin
    sq_st[0].rad  = (qte_pkg::RadW'(1) << 60) - sq_q;
    sq_st[0].rem  = '0;
    sq_st[0].root = '0;
  end
  assign side_st[0] = side4_q;
  assign sv_q[0]    = v4_q;

  for (genvar k = 0; k < NSq; k++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .in_i  (sq_st[k]),
      .out_o (sq_st[k+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) side_st[k+1] <= side_st[k];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else if (en) sv_q[k+1] <= sv_q[k];
    end
  end

  // cordic lanes: roll, pitch, yaw
  qte_pkg::cordic_vec_t cr_st [3][CORDIC_STAGES+1];
  qte_pkg::clamp_t      cl_st [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] cv_q;
  qte_pkg::side_t       sl;

  assign sl = side_st[NSq];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_st[0][0] <= qte_pkg::prep(CordW'(sl.sr), CordW'(sl.cr));
      cr_st[1][0] <= qte_pkg::prep(CordW'(sl.s30),
                                   CordW'({1'b0, sq_st[NSq].root}));
      cr_st[2][0] <= qte_pkg::prep(CordW'(sl.sy), CordW'(sl.cy));
      cl_st[0]    <= '{hi: sl.hi, lo: sl.lo};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cv_q[0] <= 1'b0;
    else if (en) cv_q[0] <= sv_q[NSq];
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      qte_cordic_cell #(.Idx(i)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .in_i  (cr_st[l][i]),
        .out_o (cr_st[l][i+1])
      );
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_ctl
    always_ff @(posedge clk_i) begin
      if (en) cl_st[i+1] <= cl_st[i];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cv_q[i+1] <= 1'b0;
      else if (en) cv_q[i+1] <= cv_q[i];
    end
  end

  // front valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // output register
  qte_pkg::clamp_t       cl_out;
  logic [15:0]           pitch_d;
  logic                  out_valid_q;
  logic [47:0]           out_data_q;
  logic                  out_user_q;

  assign cl_out = cl_st[CORDIC_STAGES];

  always_comb begin
    if (cl_out.hi)      pitch_d = 16'h4000;
    else if (cl_out.lo) pitch_d = 16'hC000;
    else                pitch_d = qte_pkg::round_ang(cr_st[1][CORDIC_STAGES]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= cv_q[CORDIC_STAGES];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {qte_pkg::round_ang(cr_st[2][CORDIC_STAGES]), pitch_d,
                     qte_pkg::round_ang(cr_st[0][CORDIC_STAGES])};
      out_user_q <= cl_out.hi | cl_out.lo;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

### src/qte_checker.sv
// ----------------------------------------------------------------------------
// qte_checker
// Port level checks for the quaternion to euler angle block.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [47:0] m_axis_tdata,
  input wire        m_axis_tuser
);

  // output beat holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed");

  // clamped pitch is a quarter turn
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[31:16] == 16'h4000) || (m_axis_tdata[31:16] == 16'hC000))
    else $error("clamped pitch not a quarter turn");

  // ready follows the output stall
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready wrong");

  // no output beat in reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid in reset");

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
